@@ sv/sbbm_pkg.sv @@
package sbbm_pkg;

  localparam int unsigned MAX_BANDS_DEF = 512;
  localparam int unsigned MAX_FFT_DEF   = 8192;

  localparam int unsigned BIN_W   = 13;
  localparam int unsigned HZ_W    = 23;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned PROD_W  = HZ_W + SCALE_W;

  localparam logic [23:0] SCALE_RST = 24'd715828;
  localparam logic [22:0] BW_RST    = 23'd6000;
  localparam logic [12:0] TOP_RST   = 13'd1025;

  // register word index (byte address / 4)
  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_BW    = 2'd1;
  localparam logic [1:0] REG_TOP   = 2'd2;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_BAND  = 2'd2;
  localparam logic [1:0] STATUS_NO_START = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [22:0] edge_hz;
    logic [12:0] bin_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  band_index;
    logic [12:0] bin_low;
    logic [12:0] bin_end;
    logic        narrow_flag;
    logic [9:0]  band_total;
  } rsp_t;

endpackage

@@ sv/spectrum_band_bin_mapper.sv @@
// spectrum band bin mapper
// software writes the band edges as requests on the in channel: a start
// request sets the first edge and empties the table, each append request
// closes one band and stores its bin range [low, high), and a lookup request
// returns the lowest-numbered band whose range holds the given bin.
// every request except func three gives one response on the out channel.
// a start request goes straight to the push state; an append passes
// through the conv_lo, conv_hi and append states (one shared 23x24
// multiplier converts both edges); a lookup scans the band table up to the
// matching band, or through every band on a miss; a lookup on an empty
// table goes straight to push. the scan reads one entry per cycle from a ram
// with registered read data, so lookup time grows with the matching band's index.
// the next request is taken as soon as the previous one has handed its
// response to the output register; a stalled receiver holds that register,
// and a request finishing behind it waits until it drains.
// reset clears the edge history, the band count and the registers to their
// defaults; the table ram is not cleared and needs no clearing pass.
// configuration is an apb-style port, registers at byte addresses 0, 4, 8.
module spectrum_band_bin_mapper #(
  parameter int unsigned MaxBands = sbbm_pkg::MAX_BANDS_DEF,
  parameter int unsigned MaxFft   = sbbm_pkg::MAX_FFT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbbm_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbbm_pkg::rsp_t      out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW     = (MaxBands > 1) ? $clog2(MaxBands) : 1;
  localparam int unsigned CntW     = $clog2(MaxBands + 1);
  localparam int unsigned TopLimit = MaxFft / 2 + 1;
  localparam int unsigned BinW     = sbbm_pkg::BIN_W;
  localparam int unsigned HzW      = sbbm_pkg::HZ_W;
  localparam int unsigned PrW      = sbbm_pkg::PROD_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CONV_LO = 3'd1;
  localparam logic [2:0] ST_CONV_HI = 3'd2;
  localparam logic [2:0] ST_APPEND  = 3'd3;
  localparam logic [2:0] ST_SCAN    = 3'd4;
  localparam logic [2:0] ST_PUSH    = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [HzW-1:0]    edge_q, edge_d;
  logic [BinW-1:0]   bin_q, bin_d;
  logic [23:0]       scale_q;
  logic [22:0]       bw_q;
  logic [12:0]       top_q;
  logic [HzW-1:0]    last_edge_q, last_edge_d;
  logic [BinW-1:0]   last_high_q, last_high_d;
  logic              have_edge_q, have_edge_d;
  logic [CntW-1:0]   tally_q, tally_d;
  logic [PrW-1:0]    prod_q, prod_d;
  logic [BinW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  sbbm_pkg::rsp_t    res_q, res_d;
  sbbm_pkg::rsp_t    out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // band table ram
  logic [2*BinW-1:0] mem [MaxBands];
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_wa, mem_ra;
  logic [2*BinW-1:0] mem_wd, rd_data_q;

  logic              cfg_wr;
  logic              in_acc;
  logic [BinW-1:0]   top_eff, top_m1;
  logic [HzW-1:0]    mul_a;
  logic [15:0]       conv;
  logic [15:0]       lo_sel;
  logic [BinW:0]     lo_p1;
  logic [15:0]       hi_sel;
  logic [BinW-1:0]   hi_fin;
  logic              narrow;
  logic [CntW-1:0]   tally_inc;
  logic [31:0]       tally_w, tally_inc_w, idx_w, cmp_w;
  logic [BinW-1:0]   rd_lo, rd_hi;
  logic              hit, last_cmp;
  logic              push;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      sbbm_pkg::REG_SCALE: prdata = {8'd0, scale_q};
      sbbm_pkg::REG_BW:    prdata = {9'd0, bw_q};
      sbbm_pkg::REG_TOP:   prdata = {19'd0, top_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= sbbm_pkg::SCALE_RST;
      bw_q    <= sbbm_pkg::BW_RST;
      top_q   <= sbbm_pkg::TOP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sbbm_pkg::REG_SCALE: scale_q <= pwdata[23:0];
        sbbm_pkg::REG_BW:    bw_q    <= pwdata[22:0];
        sbbm_pkg::REG_TOP:   top_q   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // effective top bin, limited to [1, fft/2+1]
  always_comb begin
    if (32'(top_q) > TopLimit) begin
      top_eff = BinW'(TopLimit);
    end else if (top_q == '0) begin
      top_eff = BinW'(1);
    end else begin
      top_eff = top_q;
    end
    top_m1 = top_eff - BinW'(1);
  end

  // shared converter: round half up of hz * scale / 2^32
  assign mul_a  = (state_q == ST_CONV_LO) ? last_edge_q : edge_q;
  assign prod_d = PrW'(mul_a) * PrW'(scale_q);
  assign conv   = 16'(prod_q[PrW-1:32]) + 16'(prod_q[31]);

  assign lo_sel = (conv < 16'(last_high_q)) ? 16'(last_high_q) : conv;
  assign lo_p1  = (BinW+1)'(lo_q) + (BinW+1)'(1);
  assign hi_sel = (conv < 16'(lo_p1)) ? 16'(lo_p1) : conv;
  assign hi_fin = (hi_sel > 16'(top_eff)) ? top_eff : hi_sel[BinW-1:0];
  assign narrow = (edge_q <= last_edge_q) || ((edge_q - last_edge_q) < bw_q);

  assign tally_inc   = tally_q + CntW'(1);
  assign tally_w     = 32'(tally_q);
  assign tally_inc_w = 32'(tally_inc);
  assign idx_w       = 32'(tally_q);
  assign cmp_w       = 32'(cmp_idx_q);

  assign rd_lo    = rd_data_q[2*BinW-1:BinW];
  assign rd_hi    = rd_data_q[BinW-1:0];
  assign hit      = cmp_vld_q && (bin_q >= rd_lo) && (bin_q < rd_hi);
  assign last_cmp = cmp_vld_q && ((cmp_w + 32'd1) == tally_w);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign push       = (state_q == ST_PUSH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    edge_d      = edge_q;
    bin_d       = bin_q;
    last_edge_d = last_edge_q;
    last_high_d = last_high_q;
    have_edge_d = have_edge_q;
    tally_d     = tally_q;
    lo_d        = lo_q;
    ptr_d       = ptr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_wa      = tally_q[IdxW-1:0];
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = ptr_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          edge_d = in_req_i.edge_hz;
          bin_d  = in_req_i.bin_index;
          res_d  = '0;
          res_d.band_total = tally_w[9:0];
          unique case (in_req_i.func)
            sbbm_pkg::FUNC_START: begin
              last_edge_d = in_req_i.edge_hz;
              last_high_d = '0;
              have_edge_d = 1'b1;
              tally_d     = '0;
              res_d.band_total = '0;
              state_d     = ST_PUSH;
            end
            sbbm_pkg::FUNC_APPEND: begin
              if (!have_edge_q) begin
                res_d.status = sbbm_pkg::STATUS_NO_START;
                state_d      = ST_PUSH;
              end else if (tally_w >= MaxBands) begin
                res_d.status = sbbm_pkg::STATUS_FULL;
                state_d      = ST_PUSH;
              end else begin
                state_d = ST_CONV_LO;
              end
            end
            sbbm_pkg::FUNC_LOOKUP: begin
              if (tally_q == '0) begin
                res_d.status = sbbm_pkg::STATUS_NO_BAND;
                state_d      = ST_PUSH;
              end else begin
                ptr_d   = '0;
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CONV_LO: begin
        state_d = ST_CONV_HI;
      end
      ST_CONV_HI: begin
        // low edge bin, raised to the previous high and kept below top
        lo_d    = (lo_sel > 16'(top_m1)) ? top_m1 : lo_sel[BinW-1:0];
        state_d = ST_APPEND;
      end
      ST_APPEND: begin
        mem_we      = 1'b1;
        mem_wd      = {lo_q, hi_fin};
        tally_d     = tally_inc;
        last_edge_d = edge_q;
        last_high_d = hi_fin;
        res_d.status      = sbbm_pkg::STATUS_OK;
        res_d.band_index  = idx_w[8:0];
        res_d.bin_low     = lo_q;
        res_d.bin_end     = hi_fin;
        res_d.narrow_flag = narrow;
        res_d.band_total  = tally_inc_w[9:0];
        state_d = ST_PUSH;
      end
      ST_SCAN: begin
        // read entry ptr while comparing the entry read the cycle before
        if (hit) begin
          res_d.status     = sbbm_pkg::STATUS_OK;
          res_d.band_index = cmp_w[8:0];
          state_d          = ST_PUSH;
        end else if (last_cmp) begin
          res_d.status = sbbm_pkg::STATUS_NO_BAND;
          state_d      = ST_PUSH;
        end else if (ptr_q < tally_q) begin
          mem_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q;
          ptr_d     = ptr_q + CntW'(1);
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (push) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_edge_q <= '0;
      last_high_q <= '0;
      have_edge_q <= 1'b0;
      tally_q     <= '0;
      ptr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_edge_q <= last_edge_d;
      last_high_q <= last_high_d;
      have_edge_q <= have_edge_d;
      tally_q     <= tally_d;
      ptr_q       <= ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q    <= edge_d;
    bin_q     <= bin_d;
    prod_q    <= prod_d;
    lo_q      <= lo_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
